// ===== hw/rtl/cfpr_pkg.sv =====
// Package for the CRC framed packet receiver.
// Holds the frame layout positions, CRC constants and the result type.
// No dependencies; every other file but cfpr_if.sv and cfpr_checker.sv imports it.
package cfpr_pkg;

   // CRC-16 with polynomial 0x1021, seed 0xFFFF, MSB first.
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // Reset value of the start byte register.
   localparam logic [7:0] START_RESET = 8'h01;

   // Width of the byte position counter within a frame.
   localparam int COUNT_W = 9;

   // Byte positions within a frame.
   localparam logic [COUNT_W-1:0] POS_START  = 9'd0;
   localparam logic [COUNT_W-1:0] POS_CRC_HI = 9'd1;
   localparam logic [COUNT_W-1:0] POS_CRC_LO = 9'd2;
   localparam logic [COUNT_W-1:0] POS_LENGTH = 9'd3;
   localparam logic [COUNT_W-1:0] POS_MSG0   = 9'd4;
   localparam logic [COUNT_W-1:0] POS_MSG1   = 9'd5;

   // Length values below this give a zero payload word.
   localparam logic [7:0] MIN_PAYLOAD_LEN = 8'd2;

   // One finished frame.
   typedef struct packed {
      logic              crc_ok;
      logic signed [15:0] payload_word;
      logic [7:0]        message_length;
   } result_type;

endpackage

// ===== hw/rtl/cfpr_if.sv =====
// Channel interfaces of the CRC framed packet receiver.
// Request (received bytes), response (finished frames) and register write channels.
// No dependencies.
interface cfpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpr_rsp_if;
   logic               valid;
   logic               ready;
   logic               crc_ok;
   logic signed [15:0] payload_word;
   logic [7:0]         message_length;

   modport source (output valid, output crc_ok, output payload_word,
                   output message_length, input ready);
   modport sink (input valid, input crc_ok, input payload_word,
                 input message_length, output ready);
endinterface

interface cfpr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] start_value;

   modport source (output valid, output start_value, input ready);
   modport sink (input valid, input start_value, output ready);
endinterface

// ===== hw/rtl/cfpr_crc_step.sv =====
// One-byte CRC-16 update, MSB first, as eight unrolled shift steps.
// Depends on cfpr_pkg for the polynomial.
module cfpr_crc_step (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);
   import cfpr_pkg::*;

   // The byte enters the top of the register, then eight conditional XOR shifts.
   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((acc & CRC_TOP) != 16'h0000) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

// ===== hw/rtl/cfpr_frame_ctrl.sv =====
// Frame tracking for the CRC framed packet receiver: position counter, captured
// CRC, length, payload bytes and running CRC. Depends on cfpr_pkg and cfpr_crc_step.
module cfpr_frame_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           start_value,
   output logic                 result_valid,
   output cfpr_pkg::result_type result
);
   import cfpr_pkg::*;

   logic               receiving_ff, receiving_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        captured_ff, captured_in;
   logic [7:0]         length_ff, length_in;
   logic [15:0]        hold_ff, hold_in;

   logic               start_hit;
   logic               rcv_base;
   logic [COUNT_W-1:0] count_base;
   logic [15:0]        crc_base;
   logic [15:0]        captured_base;
   logic [7:0]         length_base;
   logic [15:0]        hold_base;
   logic [15:0]        crc_stepped;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] frame_end;
   logic               finish;

   // A start byte restarts the frame wherever it falls.
   assign start_hit     = (rx_byte == start_value);
   assign rcv_base      = start_hit | receiving_ff;
   assign count_base    = start_hit ? POS_START : count_ff;
   assign crc_base      = start_hit ? CRC_SEED : crc_ff;
   assign captured_base = start_hit ? 16'h0000 : captured_ff;
   assign length_base   = start_hit ? 8'h00 : length_ff;
   assign hold_base     = start_hit ? 16'h0000 : hold_ff;

   cfpr_crc_step u_crc_step (
      .crc_cur   (crc_base),
      .data_byte (rx_byte),
      .crc_next  (crc_stepped)
   );

   assign count_inc = count_base + COUNT_W'(1);
   assign frame_end = {1'b0, length_base} + COUNT_W'(4);

   // Next frame state for the byte at its position.
   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_base;
      crc_in       = crc_base;
      captured_in  = captured_base;
      length_in    = length_base;
      hold_in      = hold_base;
      finish       = 1'b0;
      if (rcv_base) begin
         receiving_in = 1'b1;
         unique case (count_base)
            POS_START: begin
               count_in = POS_CRC_HI;
            end
            POS_CRC_HI: begin
               captured_in = {rx_byte, 8'h00};
               count_in    = POS_CRC_LO;
            end
            POS_CRC_LO: begin
               captured_in = {captured_base[15:8], rx_byte};
               count_in    = POS_LENGTH;
            end
            POS_LENGTH: begin
               length_in = rx_byte;
               count_in  = POS_MSG0;
               finish    = (rx_byte == 8'h00);
            end
            default: begin
               crc_in = crc_stepped;
               if (count_base == POS_MSG0) begin
                  hold_in = {rx_byte, 8'h00};
               end else if (count_base == POS_MSG1) begin
                  hold_in = {hold_base[15:8], rx_byte};
               end
               count_in = count_inc;
               finish   = (count_inc >= frame_end);
            end
         endcase
         if (finish) begin
            receiving_in = 1'b0;
         end
      end
   end

   // Result of a frame that ends on this byte.
   always_comb begin
      result_valid          = step_en & finish;
      result.crc_ok         = (crc_in == captured_in);
      result.payload_word   = (length_in >= MIN_PAYLOAD_LEN) ? hold_in : 16'sh0000;
      result.message_length = length_in;
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= POS_START;
         crc_ff       <= CRC_SEED;
         captured_ff  <= 16'h0000;
         length_ff    <= 8'h00;
         hold_ff      <= 16'h0000;
      end else if (step_en) begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         captured_ff  <= captured_in;
         length_ff    <= length_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

// ===== hw/rtl/cfpr_out_reg.sv =====
// Result register of the CRC framed packet receiver, driving the response channel.
// Depends on cfpr_pkg for the result type.
module cfpr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cfpr_pkg::result_type load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output cfpr_pkg::result_type rsp_data,
   output logic                 can_load
);
   import cfpr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register may take a new result when empty or drained this cycle.
   assign can_load = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load & load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/crc_framed_packet_receiver.sv =====
// CRC framed packet receiver: start byte, CRC high, CRC low, length, message bytes.
// A frame's last byte is held in the input register, and its result is then registered in the
// result register, which drives the response channel until rsp ready takes it.
// Throughput: one byte per cycle, set by the combinational pass (unrolled CRC) between the
// input and result registers; bytes stall only while a finished result waits for rsp ready.
// Reset (synchronous, active high): idle, both valid flags cleared, start byte set to 0x01.
module crc_framed_packet_receiver (
   input logic      clock,
   input logic      reset,
   cfpr_req_if.sink   req_chan,
   cfpr_rsp_if.source rsp_chan,
   cfpr_csr_if.sink   csr_chan
);
   import cfpr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] start_value_ff;
   logic       advance;
   logic       req_take;
   logic       can_load;
   logic       result_valid;
   result_type result;
   result_type rsp_data;
   logic       rsp_valid;

   // Start byte register; writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= START_RESET;
      end else if (csr_chan.valid) begin
         start_value_ff <= csr_chan.start_value;
      end
   end

   // Input register: the held byte moves on when the result register can take its result.
   assign advance        = in_valid_ff & can_load;
   assign req_chan.ready = ~in_valid_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   cfpr_frame_ctrl u_frame_ctrl (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .rx_byte      (in_byte_ff),
      .start_value  (start_value_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   cfpr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   // Response channel.
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.crc_ok         = rsp_data.crc_ok;
   assign rsp_chan.payload_word   = rsp_data.payload_word;
   assign rsp_chan.message_length = rsp_data.message_length;

endmodule

// ===== hw/rtl/cfpr_checker.sv =====
// Port-level checks for the CRC framed packet receiver, attached by a bind.
// Depends on the top level crc_framed_packet_receiver and its channel interfaces.
module cfpr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              crc_ok,
   input logic signed [15:0] payload_word,
   input logic [7:0]        message_length
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(crc_ok) &&
      $stable(payload_word) && $stable(message_length))
      else $error("stalled result changed");

   // Frames shorter than two message bytes carry a zero payload word.
   a_short_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (message_length == 8'd0 || message_length == 8'd1) |->
      payload_word == 16'sh0000)
      else $error("short frame with non-zero payload word");

   // A new result follows a byte transaction, by way of the input and result registers.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a byte transaction");

   // With no result waiting the receiver always takes a byte.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("byte refused while result register empty");

endmodule

bind crc_framed_packet_receiver cfpr_checker u_cfpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .crc_ok         (rsp_chan.crc_ok),
   .payload_word   (rsp_chan.payload_word),
   .message_length (rsp_chan.message_length)
);

// ===== tb/cfpr_frame_checker.sv =====
// Frame checker for the CRC framed packet receiver testbench.
// Watches the byte, result and register channels, predicts every finished frame and compares.
// Depends on cfpr_pkg and the channel interfaces in cfpr_if.sv.
module cfpr_frame_checker (
   input  logic clock,
   input  logic reset,
   cfpr_req_if  req_mon,
   cfpr_rsp_if  rsp_mon,
   cfpr_csr_if  csr_mon,
   output int   mismatches,
   output int   frames_awaited
);
   import cfpr_pkg::*;

   // Predicted receiver state and the start byte register.
   logic [7:0]         start_byte;
   logic               in_frame;
   logic [COUNT_W-1:0] frame_pos;
   logic [15:0]        crc_sum;
   logic [15:0]        crc_sent;
   logic [7:0]         len_field;
   logic [15:0]        first_pair;
   result_type         expected_frames[$];
   int                 fail_count = 0;

   // One byte of CRC-16, polynomial 0x1021, most significant bit first.
   function automatic logic [15:0] crc_after_byte(input logic [15:0] crc_in,
                                                  input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_in ^ {data, 8'h00};
      repeat (8) crc = (crc & CRC_TOP) ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      return crc;
   endfunction

   // The frame is complete: queue the result that the block should give.
   task automatic close_frame();
      result_type frame;
      in_frame             = 1'b0;
      frame.crc_ok         = (crc_sum == crc_sent);
      frame.payload_word   = (len_field >= MIN_PAYLOAD_LEN) ? first_pair : 16'h0000;
      frame.message_length = len_field;
      expected_frames.push_back(frame);
   endtask

   // Advance the predicted state by one received byte.
   task automatic take_byte(input logic [7:0] b);
      // A start byte restarts reception wherever it falls.
      if (b == start_byte) begin
         in_frame   = 1'b1;
         frame_pos  = POS_START;
         crc_sum    = CRC_SEED;
         crc_sent   = 16'h0000;
         len_field  = 8'h00;
         first_pair = 16'h0000;
      end
      if (in_frame) begin
         case (frame_pos)
            POS_START: begin
               frame_pos = POS_CRC_HI;
            end
            POS_CRC_HI: begin
               crc_sent  = {b, 8'h00};
               frame_pos = POS_CRC_LO;
            end
            POS_CRC_LO: begin
               crc_sent[7:0] = b;
               frame_pos     = POS_LENGTH;
            end
            POS_LENGTH: begin
               len_field = b;
               frame_pos = POS_MSG0;
               if (b == 8'h00) close_frame();
            end
            default: begin
               crc_sum = crc_after_byte(crc_sum, b);
               if (frame_pos == POS_MSG0) first_pair[15:8] = b;
               else if (frame_pos == POS_MSG1) first_pair[7:0] = b;
               frame_pos = frame_pos + 1'b1;
               if (frame_pos >= POS_MSG0 + len_field) close_frame();
            end
         endcase
      end
   endtask

   // Compare a result transaction with the oldest expected frame.
   task automatic check_frame();
      result_type want;
      if (expected_frames.size() == 0) begin
         $error("unexpected result: crc_ok %0d, payload_word %0d, message_length %0d",
                rsp_mon.crc_ok, rsp_mon.payload_word, rsp_mon.message_length);
         fail_count++;
      end else begin
         want = expected_frames.pop_front();
         if (rsp_mon.crc_ok !== want.crc_ok) begin
            $error("crc_ok: expected %0d, got %0d", want.crc_ok, rsp_mon.crc_ok);
            fail_count++;
         end
         if (rsp_mon.payload_word !== want.payload_word) begin
            $error("payload_word: expected %0d, got %0d",
                   want.payload_word, rsp_mon.payload_word);
            fail_count++;
         end
         if (rsp_mon.message_length !== want.message_length) begin
            $error("message_length: expected %0d, got %0d",
                   want.message_length, rsp_mon.message_length);
            fail_count++;
         end
      end
   endtask

   // Sample every channel at the clock edge; register writes come before bytes.
   always @(posedge clock) begin
      if (reset) begin
         start_byte = START_RESET;
         in_frame   = 1'b0;
         frame_pos  = POS_START;
         crc_sum    = CRC_SEED;
         crc_sent   = 16'h0000;
         len_field  = 8'h00;
         first_pair = 16'h0000;
         expected_frames.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) start_byte = csr_mon.start_value;
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_frame();
      end
      mismatches     <= fail_count;
      frames_awaited <= expected_frames.size();
   end

endmodule

// ===== tb/tb_crc_framed_packet_receiver.sv =====
// Testbench top for the CRC framed packet receiver.
// Drives bytes, register writes and result back-pressure; the frame checker does the comparing.
// Depends on cfpr_pkg, cfpr_if.sv, the receiver RTL and cfpr_frame_checker.
module tb_crc_framed_packet_receiver;
   import cfpr_pkg::*;

   localparam int FRAME_BYTE_BUDGET = 1100;
   localparam int SEGMENTS          = 6;

   logic       clock = 1'b0;
   logic       reset;
   int         mismatches;
   int         frames_awaited;
   int         send_gap_pct  = 30;
   int         rsp_stall_pct = 46;
   int         frame_bytes   = 0;
   logic [7:0] start_now     = START_RESET;

   cfpr_req_if req_chan ();
   cfpr_rsp_if rsp_chan ();
   cfpr_csr_if csr_chan ();

   crc_framed_packet_receiver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   cfpr_frame_checker i_frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatches     (mismatches),
      .frames_awaited (frames_awaited)
   );

   // 20 time unit clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Random stalls on the result channel.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // CRC that a sender would place in front of the message bytes.
   function automatic logic [15:0] frame_crc(input logic [7:0] msg[$]);
      logic [15:0] crc;
      crc = CRC_SEED;
      foreach (msg[i]) begin
         crc ^= {msg[i], 8'h00};
         repeat (8) crc = (crc & CRC_TOP) ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
      return crc;
   endfunction

   // One byte transaction, preceded by random gaps.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // A whole frame; a non-zero crc_flip corrupts the transmitted CRC.
   task automatic send_frame(input logic [7:0] msg[$], input logic [15:0] crc_flip);
      logic [15:0] crc;
      crc = frame_crc(msg) ^ crc_flip;
      send_byte(start_now);
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
      send_byte(8'(msg.size()));
      foreach (msg[i]) send_byte(msg[i]);
   endtask

   // Wait until the block is idle, then write the start byte register.
   task automatic write_start(input logic [7:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (frames_awaited == 0);
      // Allow for a byte still between the input and result registers.
      repeat (4) @(posedge clock);
      csr_chan.valid       <= 1'b1;
      csr_chan.start_value <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      start_now = value;
   endtask

   // Frame with random content, its CRC sometimes corrupted; a negative len_pick asks for a random length.
   task automatic random_frame(input int len_pick);
      logic [7:0] msg[$];
      logic [7:0] b;
      int         pick;
      int         len;
      len  = len_pick;
      pick = $urandom_range(99);
      if (len < 0) begin
         if (pick < 10) len = 0;
         else if (pick < 20) len = 1;
         else if (pick < 98) len = $urandom_range(12, 2);
         else len = $urandom_range(255, 100);
      end
      if (8'(len) == start_now) len = len ^ 1;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (b == start_now) b ^= 8'h01;
         msg.push_back(b);
      end
      frame_bytes += 4 + len;
      send_frame(msg, ($urandom_range(99) < 75) ? 16'h0000 : 16'($urandom_range(16'hFFFF, 1)));
   endtask

   // Stray bytes, sometimes behind a start byte so that a frame is cut short.
   task automatic send_noise();
      int n;
      n = $urandom_range(6, 1);
      if ($urandom_range(1) == 1) send_byte(start_now);
      repeat (n) send_byte(8'($urandom));
   endtask

   // Stimulus and verdict.
   initial begin
      logic [7:0] msg[$];
      logic [7:0] seg_start[SEGMENTS];
      seg_start = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom), 8'h7E};

      req_chan.valid       = 1'b0;
      req_chan.rx_byte     = 8'h00;
      csr_chan.valid       = 1'b0;
      csr_chan.start_value = 8'h00;
      rsp_chan.ready       = 1'b0;
      reset                = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the start byte at its reset value.
      send_byte(8'h00);
      send_byte(8'hFF);
      msg = {};
      send_frame(msg, 16'h0000);
      msg = '{8'h80, 8'hFF};
      send_frame(msg, 16'h0000);
      // A frame broken off by a new start byte gives no result.
      send_byte(START_RESET);
      send_byte(8'h12);
      msg = {};
      send_frame(msg, 16'hFFFF);
      msg = '{8'h7F, 8'h00, 8'hFE};
      send_frame(msg, 16'h8001);

      // Random part: each segment begins with a register write once the block is idle.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         write_start(seg_start[seg]);
         case (seg / 2)
            0: begin
               send_gap_pct  = 30;
               rsp_stall_pct = 46;
            end
            1: begin
               send_gap_pct  = 46;
               rsp_stall_pct = 30;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         if (seg == 0) random_frame(255);
         while (frame_bytes < (seg + 1) * FRAME_BYTE_BUDGET / SEGMENTS) begin
            if ($urandom_range(99) < 80) random_frame(-1);
            else send_noise();
         end
      end

      // Drain the outstanding frames, then give the verdict.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (frames_awaited == 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && frames_awaited == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
